// ===== rtl/core/frm_pkg.sv =====
// Package for the four-register ALU machine: sizes, operation codes and the
// register-file write bundle. No dependencies.
`default_nettype none

package frm_pkg;

   localparam int NUM_REGS   = 4;
   localparam int DATA_WIDTH = 32;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);

   localparam int OPCODE_W   = 4;
   localparam int OPERAND_W  = 16;
   localparam int DEST_W     = 2;
   localparam int MAP_W      = 64;
   localparam int VALUE_W    = 32;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [3:0] {
      OP_ADDR = 4'd0,
      OP_ADDI = 4'd1,
      OP_MULR = 4'd2,
      OP_MULI = 4'd3,
      OP_BANR = 4'd4,
      OP_BANI = 4'd5,
      OP_BORR = 4'd6,
      OP_BORI = 4'd7,
      OP_SETR = 4'd8,
      OP_SETI = 4'd9,
      OP_GTIR = 4'd10,
      OP_GTRI = 4'd11,
      OP_GTRR = 4'd12,
      OP_EQIR = 4'd13,
      OP_EQRI = 4'd14,
      OP_EQRR = 4'd15
   } op_type;

   typedef struct packed {
      logic                  en;
      logic [REG_IDX_W-1:0]  addr;
      logic [DATA_WIDTH-1:0] data;
   } rf_write_type;

endpackage

`default_nettype wire

// ===== rtl/core/frm_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// A read at the address written in the same cycle returns the new data.
`default_nettype none

module frm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem_ff[rd_addr_a];
         rd_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== rtl/core/frm_regfile.sv =====
// Register file: frm_ram storage plus per-entry valid bits so that every
// register reads as zero after reset. Keeps a copy of register zero. Uses frm_pkg.
`default_nettype none

module frm_regfile
   import frm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rf_write_type          wr,
   input  wire logic                  rd_en,
   input  wire logic [REG_IDX_W-1:0]  rd_addr_a,
   input  wire logic [REG_IDX_W-1:0]  rd_addr_b,
   output logic      [DATA_WIDTH-1:0] rd_data_a,
   output logic      [DATA_WIDTH-1:0] rd_data_b,
   output logic      [DATA_WIDTH-1:0] reg_zero
);

   logic [NUM_REGS-1:0]   valid_ff;
   logic                  rd_valid_a_ff;
   logic                  rd_valid_b_ff;
   logic [DATA_WIDTH-1:0] reg_zero_ff;
   logic [DATA_WIDTH-1:0] ram_a;
   logic [DATA_WIDTH-1:0] ram_b;

   frm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (NUM_REGS)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr.en),
      .wr_addr   (wr.addr),
      .wr_data   (wr.data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rd_valid_a_ff <= 1'b0;
         rd_valid_b_ff <= 1'b0;
         reg_zero_ff   <= '0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
            if (wr.addr == '0) begin
               reg_zero_ff <= wr.data;
            end
         end
         if (rd_en) begin
            rd_valid_a_ff <= (wr.en && wr.addr == rd_addr_a) || valid_ff[rd_addr_a];
            rd_valid_b_ff <= (wr.en && wr.addr == rd_addr_b) || valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = rd_valid_a_ff ? ram_a : '0;
   assign rd_data_b = rd_valid_b_ff ? ram_b : '0;
   assign reg_zero  = reg_zero_ff;

endmodule

`default_nettype wire

// ===== rtl/core/frm_alu.sv =====
// Combinational ALU for the sixteen operations, register and immediate forms.
// Uses frm_pkg.
`default_nettype none

module frm_alu
   import frm_pkg::*;
(
   input  wire op_type                op,
   input  wire logic [OPERAND_W-1:0]  operand_a,
   input  wire logic [OPERAND_W-1:0]  operand_b,
   input  wire logic [DATA_WIDTH-1:0] reg_a,
   input  wire logic [DATA_WIDTH-1:0] reg_b,
   output logic      [DATA_WIDTH-1:0] result
);

   logic [DATA_WIDTH-1:0] imm_a;
   logic [DATA_WIDTH-1:0] imm_b;
   logic [DATA_WIDTH-1:0] one;

   assign imm_a = DATA_WIDTH'(operand_a);
   assign imm_b = DATA_WIDTH'(operand_b);
   assign one   = DATA_WIDTH'(1);

   always_comb begin
      case (op)
         OP_ADDR: result = reg_a + reg_b;
         OP_ADDI: result = reg_a + imm_b;
         OP_MULR: result = reg_a * reg_b;
         OP_MULI: result = reg_a * imm_b;
         OP_BANR: result = reg_a & reg_b;
         OP_BANI: result = reg_a & imm_b;
         OP_BORR: result = reg_a | reg_b;
         OP_BORI: result = reg_a | imm_b;
         OP_SETR: result = reg_a;
         OP_SETI: result = imm_a;
         OP_GTIR: result = ($signed(imm_a) > $signed(reg_b)) ? one : '0;
         OP_GTRI: result = ($signed(reg_a) > $signed(imm_b)) ? one : '0;
         OP_GTRR: result = ($signed(reg_a) > $signed(reg_b)) ? one : '0;
         OP_EQIR: result = (imm_a == reg_b) ? one : '0;
         OP_EQRI: result = (reg_a == imm_b) ? one : '0;
         OP_EQRR: result = (reg_a == reg_b) ? one : '0;
         default: result = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/four_register_alu_machine.sv =====
// Top level of the four-register ALU machine: input stage, opcode map,
// register file and result register. Uses frm_pkg, frm_regfile and frm_alu.
//
// One instruction per transaction, one transaction per cycle sustained while
// rsp_tready is high. An accepted request is registered into the execute stage,
// executed once the output register is free and its response is held there until
// taken. The rate is set by the register-file loop: each instruction writes its
// result while the following one reads, with the new value bypassed to the read.
// All registers read as zero after reset; the opcode map resets to zero and is
// loaded through csr_wr_en / csr_wr_data.
`default_nettype none

module four_register_alu_machine
   import frm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [MAP_W-1:0]      csr_wr_data,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // raw_opcode[3:0], operand_a[19:4], operand_b[35:20], dest_index[37:36], zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // written_index[1:0], written_value[33:2], reg_zero[65:34], zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   logic [MAP_W-1:0]      opcode_map_ff;
   logic                  e_valid_ff;
   logic [OPCODE_W-1:0]   e_raw_ff;
   logic [OPERAND_W-1:0]  e_a_ff;
   logic [OPERAND_W-1:0]  e_b_ff;
   logic [DEST_W-1:0]     e_dest_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic [OPERAND_W-1:0]  req_a;
   logic [OPERAND_W-1:0]  req_b;
   logic                  req_accept;
   logic                  e_fire;
   op_type                op;
   logic [DATA_WIDTH-1:0] reg_a;
   logic [DATA_WIDTH-1:0] reg_b;
   logic [DATA_WIDTH-1:0] reg_zero_cur;
   logic [DATA_WIDTH-1:0] result;
   logic [DATA_WIDTH-1:0] reg_zero_after;
   logic [REG_IDX_W-1:0]  dest;
   rf_write_type          rf_wr;

   assign req_a = req_tdata[19:4];
   assign req_b = req_tdata[35:20];

   assign e_fire     = e_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !e_valid_ff || e_fire;
   assign req_accept = req_tvalid && req_tready;

   assign op   = op_type'(opcode_map_ff[{e_raw_ff, 2'b00} +: OPCODE_W]);
   assign dest = REG_IDX_W'(e_dest_ff);

   assign rf_wr.en   = e_fire;
   assign rf_wr.addr = dest;
   assign rf_wr.data = result;

   frm_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr        (rf_wr),
      .rd_en     (req_accept),
      .rd_addr_a (req_a[REG_IDX_W-1:0]),
      .rd_addr_b (req_b[REG_IDX_W-1:0]),
      .rd_data_a (reg_a),
      .rd_data_b (reg_b),
      .reg_zero  (reg_zero_cur)
   );

   frm_alu u_alu (
      .op        (op),
      .operand_a (e_a_ff),
      .operand_b (e_b_ff),
      .reg_a     (reg_a),
      .reg_b     (reg_b),
      .result    (result)
   );

   assign reg_zero_after = (dest == '0) ? result : reg_zero_cur;
   assign rsp_data_in    = {6'd0, VALUE_W'(reg_zero_after), VALUE_W'(result), e_dest_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_map_ff <= '0;
         e_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            opcode_map_ff <= csr_wr_data;
         end
         if (req_accept) begin
            e_valid_ff <= 1'b1;
         end else if (e_fire) begin
            e_valid_ff <= 1'b0;
         end
         if (e_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         e_raw_ff  <= req_tdata[3:0];
         e_a_ff    <= req_a;
         e_b_ff    <= req_b;
         e_dest_ff <= req_tdata[37:36];
      end
      if (e_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
